// ----- hdl/der_primitive_tlv_encoder_macros.svh -----
// assertion macros shared by the checker of the der tlv encoder
// expects signals named clock and reset in the scope of each use
`ifndef DER_PRIMITIVE_TLV_ENCODER_MACROS_SVH
`define DER_PRIMITIVE_TLV_ENCODER_MACROS_SVH

// consequent on the cycle after the antecedent
`define DT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// condition that must hold on the cycle after reset
`define DT_ASSERT_AFTER_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/dertlv_pkg.sv -----
// types and constants of the der primitive tlv encoder
// no dependencies
package dertlv_pkg;

   localparam int MaxOctets  = 6;
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   typedef enum logic [3:0] {
      OP_BOOL       = 4'd0,
      OP_INT        = 4'd1,
      OP_NULL       = 4'd2,
      OP_LENGTH     = 4'd3,
      OP_OCTSTR_HDR = 4'd4,
      OP_OID_HDR    = 4'd5,
      OP_OID_FIRST  = 4'd6,
      OP_OID_ARC    = 4'd7,
      OP_RAW        = 4'd8
   } op_type;

   localparam logic [7:0] TAG_BOOLEAN = 8'h01;
   localparam logic [7:0] TAG_INTEGER = 8'h02;
   localparam logic [7:0] TAG_OCTSTR  = 8'h04;
   localparam logic [7:0] TAG_NULL    = 8'h05;
   localparam logic [7:0] TAG_OID     = 8'h06;
   localparam logic [7:0] LONG_FORM   = 8'h80;
   localparam logic [7:0] BOOL_TRUE   = 8'hFF;
   localparam logic [7:0] BOOL_FALSE  = 8'h00;
   localparam logic [7:0] FIRST_MULT  = 8'd40;

   typedef logic [2:0] count_type;

   // octets[0] goes out first; count of zero means nothing to send
   typedef struct packed {
      count_type                   count;
      logic [MaxOctets-1:0][7:0]   octets;
   } plan_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ----- hdl/der_primitive_tlv_encoder.sv -----
// channel   dir  ports                                      transaction
// req       in   req_valid/req_stall, req_op/value/first_arc one encode request
// rsp       out  rsp_valid/rsp_stall, rsp_byte_out/rsp_last one der octet
// a request has 1 to 6 octets, sent out by the one-octet-per-cycle output register
// while rsp_stall is low; its first octet passes the plan queue, then the output register
// the two-entry plan queue lets requests enter while earlier octets still drain
// reset is synchronous and empties the queue and the output register
// requests with unused op codes are accepted and produce no transaction
module der_primitive_tlv_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_op,
   input  logic [31:0] req_value,
   input  logic [1:0]  req_first_arc,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_byte_out,
   output logic        rsp_last
);
   import dertlv_pkg::*;

   plan_type         plan;
   plan_type         head;
   queue_status_type status;
   logic             push;
   logic             pop;

   dertlv_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_value     (req_value),
      .req_first_arc (req_first_arc),
      .status        (status),
      .push          (push),
      .plan          (plan)
   );

   dertlv_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .plan_in (plan),
      .pop     (pop),
      .head    (head),
      .status  (status)
   );

   dertlv_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .status       (status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_byte_out (rsp_byte_out),
      .rsp_last     (rsp_last)
   );

endmodule

// ----- hdl/dertlv_front.sv -----
// front end: takes a request and builds the octet plan for it
// depends on dertlv_pkg
module dertlv_front (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [3:0]                   req_op,
   input  logic [31:0]                  req_value,
   input  logic [1:0]                   req_first_arc,
   input  dertlv_pkg::queue_status_type status,
   output logic                         push,
   output dertlv_pkg::plan_type         plan
);
   import dertlv_pkg::*;

   typedef struct packed {
      count_type         count;
      logic [4:0][7:0]   octets;
   } len_enc_type;

   function automatic len_enc_type encode_length(input logic [31:0] len);
      len_enc_type enc;
      logic [2:0]  nbytes;
      logic [31:0] aligned;
      enc     = '0;
      nbytes  = 3'd4;
      aligned = len;
      if (len <= 32'h7F) begin
         enc.count     = 3'd1;
         enc.octets[0] = len[7:0];
      end else begin
         if (len <= 32'hFF) nbytes = 3'd1;
         else if (len <= 32'hFFFF) nbytes = 3'd2;
         else if (len <= 32'hFF_FFFF) nbytes = 3'd3;
         case (nbytes)
            3'd1:    aligned = len << 24;
            3'd2:    aligned = len << 16;
            3'd3:    aligned = len << 8;
            default: aligned = len;
         endcase
         enc.count     = nbytes + 3'd1;
         enc.octets[0] = LONG_FORM | {5'd0, nbytes};
         for (int k = 0; k < 4; k++) begin
            enc.octets[k+1] = aligned[31-8*k -: 8];
         end
      end
      return enc;
   endfunction

   len_enc_type len_enc;
   logic [2:0]  int_count;
   logic [31:0] int_aligned;
   logic [2:0]  arc_groups;
   logic [34:0] arc_aligned;

   always_comb begin
      len_enc = encode_length(req_value);

      if (req_value <= 32'h7F) int_count = 3'd1;
      else if (req_value <= 32'h7FFF) int_count = 3'd2;
      else if (req_value <= 32'h7F_FFFF) int_count = 3'd3;
      else int_count = 3'd4;
      case (int_count)
         3'd1:    int_aligned = req_value << 24;
         3'd2:    int_aligned = req_value << 16;
         3'd3:    int_aligned = req_value << 8;
         default: int_aligned = req_value;
      endcase

      // base-128 groups, left aligned in a 35 bit word
      if (req_value[31:7] == '0) arc_groups = 3'd1;
      else if (req_value[31:14] == '0) arc_groups = 3'd2;
      else if (req_value[31:21] == '0) arc_groups = 3'd3;
      else if (req_value[31:28] == '0) arc_groups = 3'd4;
      else arc_groups = 3'd5;
      case (arc_groups)
         3'd1:    arc_aligned = {3'd0, req_value} << 28;
         3'd2:    arc_aligned = {3'd0, req_value} << 21;
         3'd3:    arc_aligned = {3'd0, req_value} << 14;
         3'd4:    arc_aligned = {3'd0, req_value} << 7;
         default: arc_aligned = {3'd0, req_value};
      endcase

      plan = '0;
      case (req_op)
         OP_BOOL: begin
            plan.count     = 3'd3;
            plan.octets[0] = TAG_BOOLEAN;
            plan.octets[1] = 8'h01;
            plan.octets[2] = (req_value != '0) ? BOOL_TRUE : BOOL_FALSE;
         end
         OP_INT: begin
            plan.count     = int_count + 3'd2;
            plan.octets[0] = TAG_INTEGER;
            plan.octets[1] = {5'd0, int_count};
            for (int k = 0; k < 4; k++) begin
               plan.octets[k+2] = int_aligned[31-8*k -: 8];
            end
         end
         OP_NULL: begin
            plan.count     = 3'd2;
            plan.octets[0] = TAG_NULL;
            plan.octets[1] = 8'h00;
         end
         OP_LENGTH: begin
            plan.count       = len_enc.count;
            plan.octets[4:0] = len_enc.octets;
         end
         OP_OCTSTR_HDR: begin
            plan.count       = len_enc.count + 3'd1;
            plan.octets[0]   = TAG_OCTSTR;
            plan.octets[5:1] = len_enc.octets;
         end
         OP_OID_HDR: begin
            plan.count       = len_enc.count + 3'd1;
            plan.octets[0]   = TAG_OID;
            plan.octets[5:1] = len_enc.octets;
         end
         OP_OID_FIRST: begin
            plan.count     = 3'd1;
            plan.octets[0] = 8'({6'd0, req_first_arc} * FIRST_MULT) + req_value[7:0];
         end
         OP_OID_ARC: begin
            plan.count = arc_groups;
            for (int k = 0; k < 5; k++) begin
               plan.octets[k] = {(3'(k) != arc_groups - 3'd1), arc_aligned[34-7*k -: 7]};
            end
         end
         OP_RAW: begin
            plan.count     = 3'd1;
            plan.octets[0] = req_value[7:0];
         end
         default: plan = '0;
      endcase
   end

   // unknown ops are taken and dropped
   assign req_stall = status.full;
   assign push      = req_valid && !status.full && (plan.count != '0);

endmodule

// ----- hdl/dertlv_queue.sv -----
// small plan queue between the front and back ends
// depends on dertlv_pkg
module dertlv_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  dertlv_pkg::plan_type         plan_in,
   input  logic                         pop,
   output dertlv_pkg::plan_type         head,
   output dertlv_pkg::queue_status_type status
);
   import dertlv_pkg::*;

   plan_type                entries_ff [QueueDepth];
   logic [QueuePtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]      fill_ff, fill_in;
   logic                    do_push, do_pop;

   always_comb begin
      status.empty = (fill_ff == '0);
      status.full  = (fill_ff == (QueuePtrW+1)'(QueueDepth));
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + (QueuePtrW+1)'(do_push) - (QueuePtrW+1)'(do_pop);
      head    = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= plan_in;
      end
   end

endmodule

// ----- hdl/dertlv_back.sv -----
// back end: walks the head plan one octet a cycle into the output register while that register is empty or not stalled
// depends on dertlv_pkg
module dertlv_back (
   input  logic                         clock,
   input  logic                         reset,
   input  dertlv_pkg::plan_type         head,
   input  dertlv_pkg::queue_status_type status,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_byte_out,
   output logic                         rsp_last
);
   import dertlv_pkg::*;

   count_type   idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        load, take, is_last;

   always_comb begin
      load    = !valid_ff || !rsp_stall;
      take    = load && !status.empty;
      is_last = (idx_ff == head.count - 3'd1);
      pop     = take && is_last;
      idx_in  = idx_ff;
      if (take) begin
         idx_in = is_last ? '0 : idx_ff + 3'd1;
      end
      valid_in = load ? !status.empty : valid_ff;
      byte_in  = take ? head.octets[idx_ff] : byte_ff;
      last_in  = take ? is_last : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_byte_out = byte_ff;
   assign rsp_last     = last_ff;

endmodule

// ----- hdl/dertlv_checker.sv -----
// port-level checks of the der tlv encoder, bound to the top level
// depends on der_primitive_tlv_encoder_macros.svh
`include "der_primitive_tlv_encoder_macros.svh"

module dertlv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [3:0]  req_op,
   input logic [31:0] req_value,
   input logic [1:0]  req_first_arc,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_byte_out,
   input logic        rsp_last
);

   `DT_ASSERT_NEXT(a_req_hold, req_valid && req_stall,
      req_valid && $stable(req_op) && $stable(req_value) && $stable(req_first_arc),
      "stalled request changed")
   `DT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_byte_out) && $stable(rsp_last), "stalled octet changed")
   // no gap inside a transaction: rsp_valid stays high after each non-final octet leaves
   `DT_ASSERT_NEXT(a_no_gap, rsp_valid && !rsp_stall && !rsp_last, rsp_valid, "gap inside a transaction")
   `DT_ASSERT_AFTER_RESET(a_rst_rsp, !rsp_valid, "output valid after reset")
   `DT_ASSERT_AFTER_RESET(a_rst_req, !req_stall, "request stalled after reset")

endmodule

bind der_primitive_tlv_encoder dertlv_checker u_checker (.*);

// ----- verif/der_primitive_tlv_encoder_checker.sv -----
// checker of the der primitive tlv encoder: predicts the octets of every accepted
// request, compares them with the response channel and counts mismatches
// depends on dertlv_pkg
`timescale 1ns / 100ps

module der_primitive_tlv_encoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [3:0]  req_op,
   input  logic [31:0] req_value,
   input  logic [1:0]  req_first_arc,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_byte_out,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending_octets
);

   import dertlv_pkg::*;

   typedef struct packed {
      logic [7:0] octet;
      logic       last;
   } der_octet_type;

   localparam logic [31:0] SHORT_LEN_MAX = 32'h7F;
   localparam logic [31:0] INT1_MAX      = 32'h7F;
   localparam logic [31:0] INT2_MAX      = 32'h7FFF;
   localparam logic [31:0] INT3_MAX      = 32'h7FFFFF;
   localparam logic [31:0] LEN1_MAX      = 32'hFF;
   localparam logic [31:0] LEN2_MAX      = 32'hFFFF;
   localparam logic [31:0] LEN3_MAX      = 32'hFFFFFF;
   localparam int          ArcGroupsMax  = 5;

   der_octet_type expected_octets[$];
   logic [7:0]    encoded[$];
   der_octet_type want;
   int            mismatches = 0;

   function automatic void add_octet(input logic [7:0] octet);
      encoded.insert(encoded.size(), octet);
   endfunction

   function automatic void add_big_endian(input logic [31:0] v, input int count);
      logic [31:0] shifted;
      for (int i = count - 1; i >= 0; i--) begin
         shifted = v >> (8 * i);
         add_octet(shifted[7:0]);
      end
   endfunction

   function automatic void add_length(input logic [31:0] len);
      int count;
      if (len <= SHORT_LEN_MAX) begin
         add_octet(len[7:0]);
      end else begin
         if (len <= LEN1_MAX) count = 1;
         else if (len <= LEN2_MAX) count = 2;
         else if (len <= LEN3_MAX) count = 3;
         else count = 4;
         add_octet(LONG_FORM | 8'(count));
         add_big_endian(len, count);
      end
   endfunction

   // base-128, continuation bit on all but the final group
   function automatic void add_arc(input logic [31:0] arc);
      int          groups;
      logic [31:0] shifted;
      groups = 1;
      while (groups < ArcGroupsMax && (arc >> (7 * groups)) != 0) groups++;
      for (int i = groups - 1; i >= 0; i--) begin
         shifted = arc >> (7 * i);
         add_octet({i != 0, shifted[6:0]});
      end
   endfunction

   function automatic void encode_request(input logic [3:0] op, input logic [31:0] value,
                                          input logic [1:0] first_arc);
      int            count;
      der_octet_type item;
      encoded.delete();
      case (op)
         OP_BOOL: begin
            add_octet(TAG_BOOLEAN);
            add_octet(8'h01);
            add_octet(value != 0 ? BOOL_TRUE : BOOL_FALSE);
         end
         OP_INT: begin
            if (value <= INT1_MAX) count = 1;
            else if (value <= INT2_MAX) count = 2;
            else if (value <= INT3_MAX) count = 3;
            else count = 4;
            add_octet(TAG_INTEGER);
            add_octet(8'(count));
            add_big_endian(value, count);
         end
         OP_NULL: begin
            add_octet(TAG_NULL);
            add_octet(8'h00);
         end
         OP_LENGTH: add_length(value);
         OP_OCTSTR_HDR: begin
            add_octet(TAG_OCTSTR);
            add_length(value);
         end
         OP_OID_HDR: begin
            add_octet(TAG_OID);
            add_length(value);
         end
         OP_OID_FIRST: add_octet(8'(FIRST_MULT * 8'(first_arc) + value[7:0]));
         OP_OID_ARC: add_arc(value);
         OP_RAW: add_octet(value[7:0]);
         default: ;
      endcase
      foreach (encoded[i]) begin
         item.octet = encoded[i];
         item.last  = (i == encoded.size() - 1);
         expected_octets.insert(expected_octets.size(), item);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         // the response side first: octets out at this edge belong to older requests
         if (rsp_valid && !rsp_stall) begin
            if (expected_octets.size() == 0) begin
               $display("%0t: unexpected octet: expected none, actual %h last %b",
                        $time, rsp_byte_out, rsp_last);
               mismatches++;
            end else begin
               want = expected_octets.pop_front();
               if (rsp_byte_out !== want.octet) begin
                  $display("%0t: byte_out mismatch: expected %h, actual %h",
                           $time, want.octet, rsp_byte_out);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last mismatch: expected %b, actual %b",
                           $time, want.last, rsp_last);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) encode_request(req_op, req_value, req_first_arc);
      end
      fail_count     <= mismatches;
      pending_octets <= expected_octets.size();
   end

endmodule

// ----- verif/tb_der_primitive_tlv_encoder.sv -----
// testbench top of the der primitive tlv encoder: directed and random encode
// requests under several idle and stall mixes, verdict from the checker
// depends on dertlv_pkg, der_primitive_tlv_encoder and der_primitive_tlv_encoder_checker
`timescale 1ns / 100ps

module tb_der_primitive_tlv_encoder;

   import dertlv_pkg::*;

   localparam logic [3:0] OP_UNUSED_LO  = 4'd9;
   localparam logic [3:0] OP_UNUSED_HI  = 4'd15;
   localparam int         PhaseRequests = 80;
   localparam int         HoldOffCycles = 80;
   localparam int         TailCycles    = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_op = '0;
   logic [31:0] req_value = '0;
   logic [1:0]  req_first_arc = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_byte_out;
   logic        rsp_last;

   int fail_count;
   int pending_octets;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_requests = 0;

   der_primitive_tlv_encoder i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_value     (req_value),
      .req_first_arc (req_first_arc),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_byte_out  (rsp_byte_out),
      .rsp_last      (rsp_last)
   );

   der_primitive_tlv_encoder_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_value      (req_value),
      .req_first_arc  (req_first_arc),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_last       (rsp_last),
      .fail_count     (fail_count),
      .pending_octets (pending_octets)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver: random stalls, or a long hold-off when one is requested
   initial begin
      int stall_left;
      int hold_off_seen;
      stall_left    = 0;
      hold_off_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_off_requests != hold_off_seen) begin
            stall_left    = HoldOffCycles;
            hold_off_seen = hold_off_requests;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   task automatic send_request(input logic [3:0] op, input logic [31:0] value,
                               input logic [1:0] first_arc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_value     <= value;
      req_first_arc <= first_arc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random_request(output bit counted);
      logic [3:0]  op;
      logic [31:0] value;
      if ($urandom_range(9) == 0) op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      else op = 4'($urandom_range(OP_RAW, OP_BOOL));
      // random shift spreads values over every magnitude
      value = $urandom >> $urandom_range(31, 0);
      send_request(op, value, 2'($urandom_range(3, 0)));
      counted = (op <= OP_RAW);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_octets != 0);
   endtask

   initial begin
      int send_pcts[4];
      int recv_pcts[4];
      int accepted;
      bit counted;
      send_pcts = '{0, 79, 0, 12};
      recv_pcts = '{0, 0, 79, 12};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, every op, size boundaries, unused codes
      send_request(OP_BOOL, 32'h0, 2'd0);
      send_request(OP_BOOL, 32'h8000_0000, 2'd3);
      send_request(OP_INT, 32'h0, 2'd0);
      send_request(OP_INT, 32'h7F, 2'd0);
      send_request(OP_INT, 32'h80, 2'd0);
      send_request(OP_INT, 32'h7FFF, 2'd0);
      send_request(OP_INT, 32'h8000, 2'd0);
      send_request(OP_INT, 32'h7F_FFFF, 2'd0);
      send_request(OP_INT, 32'h80_0000, 2'd0);
      send_request(OP_INT, 32'hFFFF_FFFF, 2'd0);
      send_request(OP_NULL, 32'h5A5A_A5A5, 2'd1);
      send_request(OP_LENGTH, 32'h7F, 2'd0);
      send_request(OP_LENGTH, 32'h80, 2'd0);
      send_request(OP_LENGTH, 32'h100, 2'd0);
      send_request(OP_LENGTH, 32'h1_0000, 2'd0);
      send_request(OP_LENGTH, 32'hFFFF_FFFF, 2'd0);
      send_request(OP_OCTSTR_HDR, 32'hFFFF, 2'd0);
      send_request(OP_OID_HDR, 32'h100_0000, 2'd0);
      send_request(OP_OID_FIRST, 32'hFFFF_FFFF, 2'd2);
      send_request(OP_OID_FIRST, 32'h7, 2'd3);
      send_request(OP_OID_ARC, 32'h0, 2'd0);
      send_request(OP_OID_ARC, 32'h7F, 2'd0);
      send_request(OP_OID_ARC, 32'h80, 2'd0);
      send_request(OP_OID_ARC, 32'hFFFF_FFFF, 2'd0);
      send_request(OP_RAW, 32'hABCD_EF12, 2'd0);
      send_request(OP_UNUSED_LO, 32'hFFFF_FFFF, 2'd3);
      send_request(OP_UNUSED_HI, 32'h0, 2'd0);
      drain_results();

      // long receiver hold-off while requests keep coming, so the input backs up
      hold_off_requests++;
      for (int i = 0; i < 16; i++) send_random_request(counted);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = send_pcts[phase];
         recv_stall_pct = recv_pcts[phase];
         accepted = 0;
         while (accepted < PhaseRequests) begin
            send_random_request(counted);
            if (counted) accepted++;
         end
         drain_results();
      end

      recv_stall_pct = 0;
      repeat (TailCycles) @(posedge clock);
      if (fail_count == 0 && pending_octets == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- der_primitive_tlv_encoder.f -----
+incdir+hdl
hdl/dertlv_pkg.sv
hdl/dertlv_front.sv
hdl/dertlv_queue.sv
hdl/dertlv_back.sv
hdl/der_primitive_tlv_encoder.sv
hdl/dertlv_checker.sv
verif/der_primitive_tlv_encoder_checker.sv
verif/tb_der_primitive_tlv_encoder.sv
